// ===== src/assert_macros.svh =====
// Assertion macros for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("%m failed");
`define ASSERT_NEVER(label, clk, rstn, cond) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, cond)
`endif
`endif

// ===== src/iee_pkg.sv =====
// ----------------------------------------------------------------------------
// iee_pkg
// Shared types and constants of the infix expression evaluator.
// ----------------------------------------------------------------------------
package iee_pkg;

  localparam int unsigned OpDepth  = 32;
  localparam int unsigned ValDepth = 32;
  localparam int unsigned QDepth   = 4;

  typedef enum logic [2:0] {
    OPC_NONE = 3'd0,
    OPC_ADD  = 3'd1,
    OPC_SUB  = 3'd2,
    OPC_MUL  = 3'd3,
    OPC_DIV  = 3'd4,
    OPC_LPAR = 3'd5
  } opc_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DIV0  = 2'd1,
    ST_UNDER = 2'd2,
    ST_OVER  = 2'd3
  } status_e;

  // classified token kinds handed from front to back
  typedef enum logic [2:0] {
    TK_NUM   = 3'd0,  // push value
    TK_OP    = 3'd1,  // binary operator
    TK_LPAR  = 3'd2,
    TK_RPAR  = 3'd3,
    TK_END   = 3'd4,  // flush and emit
    TK_SKIP  = 3'd5   // no-op
  } tok_e;

  typedef struct packed {
    tok_e        kind;
    opc_e        op;
    logic        last;     // final char: flush once the token is done
    logic        num_vld;  // number ended by this token
    logic [31:0] num;
  } tok_t;

  function automatic logic [1:0] prio(opc_e op);
    case (op)
      OPC_ADD, OPC_SUB: prio = 2'd1;
      OPC_MUL, OPC_DIV: prio = 2'd2;
      default:          prio = 2'd0;
    endcase
  endfunction

  typedef enum logic [2:0] {
    BS_IDLE, BS_NUM, BS_POPCHK, BS_READ, BS_EXEC, BS_DIV, BS_EMIT
  } bstate_e;

endpackage

// ===== src/infix_expression_evaluator.sv =====
// Flow: a token passes the back engine's IDLE, NUM and POPCHK states; each reduction
// adds READ and EXEC, a division also the serial radix-2 divider state BS_DIV; a final
// operator or paren adds a NUM/POPCHK pass before the flush. Digits inside a number make no token.
// Throughput: one item per cycle into a 4-entry token queue while it has room;
// sustained rate is set by the back engine. The result register is loaded in EMIT
// when nothing is left to reduce. Reset: async active low; stack, queue and result data are not cleared.
// ----------------------------------------------------------------------------
// infix_expression_evaluator
// Shunting-yard integer calculator: front classifier, queue, stack engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module infix_expression_evaluator #(
  parameter int unsigned OP_DEPTH  = iee_pkg::OpDepth,
  parameter int unsigned VAL_DEPTH = iee_pkg::ValDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,   // is_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [31:0] value, [33:32] status, zero pad
);
  logic          fq_valid, fq_ready, qb_valid, qb_ready;
  iee_pkg::tok_t fq_tok, qb_tok;
  logic [31:0]   rval;
  logic [1:0]    rstat;
  logic          res_err;

  // front: digits build numbers, chars become tokens
  iee_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .char_i(s_axis_tdata), .last_i(s_axis_tlast),
    .tok_valid_o(fq_valid), .tok_ready_i(fq_ready), .tok_o(fq_tok)
  );

  iee_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(fq_valid), .wr_ready_o(fq_ready), .wr_data_i(fq_tok),
    .rd_valid_o(qb_valid), .rd_ready_i(qb_ready), .rd_data_o(qb_tok)
  );

  // back: stacks, reductions, divider, result register
  iee_back #(.OpDepth(OP_DEPTH), .ValDepth(VAL_DEPTH)) u_back (
    .clk_i, .rst_ni,
    .tok_valid_i(qb_valid), .tok_ready_o(qb_ready), .tok_i(qb_tok),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .res_value_o(rval), .res_status_o(rstat)
  );

  assign m_axis_tdata = {6'd0, rstat, rval};
  assign res_err = m_axis_tvalid && (rstat != iee_pkg::ST_OK);

  `ASSERT_IMPL(a_err_zero, clk_i, rst_ni, res_err |-> (rval == 32'd0))
  `ASSERT_NEVER(a_pad_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[39:34] != 6'd0)
  `ASSERT_IMPL(a_q_take, clk_i, rst_ni, (fq_valid && !fq_ready) |-> !s_axis_tready)
endmodule

// ===== src/iee_front.sv =====
// ----------------------------------------------------------------------------
// iee_front
// Accepts characters, builds numbers, classifies tokens into the queue.
// ----------------------------------------------------------------------------
module iee_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      char_i,
  input  logic            last_i,
  output logic            tok_valid_o,
  input  logic            tok_ready_i,
  output iee_pkg::tok_t   tok_o
);

  logic [31:0] part_q, part_d;
  logic        innum_q, innum_d;
  logic        digit, acc;
  iee_pkg::tok_t tok;

  assign digit = (char_i >= 8'h30) && (char_i <= 8'h39);
  assign in_ready_o = tok_ready_i;
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    tok = '0;
    tok.num = part_q;
    tok.num_vld = innum_q && !digit;
    tok.op = iee_pkg::OPC_NONE;
    tok.kind = iee_pkg::TK_SKIP;
    tok.last = last_i;
    if (last_i) begin
      tok.kind = iee_pkg::TK_END;
      tok.num_vld = innum_q || digit;
      tok.num = digit ? part_d : part_q;
    end
    if (!digit) begin
      case (char_i)
        8'h2B: begin tok.kind = iee_pkg::TK_OP; tok.op = iee_pkg::OPC_ADD; end
        8'h2D: begin tok.kind = iee_pkg::TK_OP; tok.op = iee_pkg::OPC_SUB; end
        8'h2A: begin tok.kind = iee_pkg::TK_OP; tok.op = iee_pkg::OPC_MUL; end
        8'h2F: begin tok.kind = iee_pkg::TK_OP; tok.op = iee_pkg::OPC_DIV; end
        8'h28: tok.kind = iee_pkg::TK_LPAR;
        8'h29: tok.kind = iee_pkg::TK_RPAR;
        default: ;
      endcase
    end
  end

  always_comb begin
    part_d = part_q;
    innum_d = innum_q;
    if (digit) begin
      part_d = (part_q << 3) + (part_q << 1) + {24'd0, char_i - 8'h30};
      innum_d = 1'b1;
    end else begin
      part_d = '0;
      innum_d = 1'b0;
    end
    if (last_i) innum_d = 1'b0;
  end

  // last token carries its own flush; a digit char with no end only extends the number and makes no token
  assign tok_valid_o = acc && (tok.kind != iee_pkg::TK_SKIP || tok.num_vld);
  assign tok_o = tok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q <= '0;
      innum_q <= 1'b0;
    end else if (acc) begin
      part_q <= last_i ? 32'd0 : part_d;
      innum_q <= innum_d;
    end
  end

endmodule

// ===== src/iee_queue.sv =====
// ----------------------------------------------------------------------------
// iee_queue
// Small token FIFO between front and back.
// ----------------------------------------------------------------------------
module iee_queue #(
  parameter int unsigned Depth = iee_pkg::QDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  iee_pkg::tok_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output iee_pkg::tok_t rd_data_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  iee_pkg::tok_t    mem_q [Depth];
  logic [AW-1:0]    wp_q, rp_q;
  logic [AW:0]      cnt_q;
  logic             wr, rd;

  assign wr_ready_o = cnt_q != (AW+1)'(Depth);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (rd) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end
endmodule

// ===== src/iee_back.sv =====
// ----------------------------------------------------------------------------
// iee_back
// Executes tokens on operator and value stacks; serial divider.
// ----------------------------------------------------------------------------
module iee_back #(
  parameter int unsigned OpDepth  = iee_pkg::OpDepth,
  parameter int unsigned ValDepth = iee_pkg::ValDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          tok_valid_i,
  output logic          tok_ready_o,
  input  iee_pkg::tok_t tok_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output logic [31:0]   res_value_o,
  output logic [1:0]    res_status_o
);
  localparam int unsigned OAW = $clog2(OpDepth);
  localparam int unsigned VAW = $clog2(ValDepth);

  iee_pkg::opc_e ostk_q [OpDepth];
  logic [31:0]   vstk_q [ValDepth];
  logic [OAW:0]  ocnt_q, ocnt_d;
  logic [VAW:0]  vcnt_q, vcnt_d;
  logic [1:0]    err_q, err_d;
  iee_pkg::bstate_e st_q, st_d;
  iee_pkg::tok_t tok_q, tok_d;
  iee_pkg::opc_e otop_q, cur_q, cur_d;
  logic [31:0]   a_q, b_q, a_d, b_d;
  logic          o_wr, v_wr;
  logic [OAW-1:0] o_wa;
  logic [VAW-1:0] v_wa;
  iee_pkg::opc_e o_wd;
  logic [31:0]   v_wd;
  logic          rvld_q, rvld_d;
  logic [31:0]   rval_q, rval_d;
  logic [1:0]    rst_q, rst_d;
  // divider
  logic [31:0]   dq_q, dq_d, dr_q, dr_d, dd_q, dd_d;
  logic [5:0]    dc_q, dc_d;
  logic          dneg_q, dneg_d;
  logic [32:0]   dsub;
  logic [31:0]   dshift;
  logic          stop;

  function automatic logic [1:0] fl(logic [1:0] e, iee_pkg::status_e c);
    fl = (e == iee_pkg::ST_OK) ? c : e;
  endfunction

  assign dshift = {dr_q[30:0], dq_q[31]};
  assign dsub = {1'b0, dshift} - {1'b0, dd_q};

  assign res_valid_o = rvld_q;
  assign res_value_o = rval_q;
  assign res_status_o = rst_q;

  // pop condition for top operator by current token
  always_comb begin
    stop = 1'b1;
    case (tok_q.kind)
      iee_pkg::TK_OP:   stop = !(ocnt_q != '0 &&
                               iee_pkg::prio(otop_q) >= iee_pkg::prio(tok_q.op));
      iee_pkg::TK_RPAR: stop = !(ocnt_q != '0 && otop_q != iee_pkg::OPC_LPAR);
      iee_pkg::TK_END:  stop = (ocnt_q == '0);
      default:          stop = 1'b1;
    endcase
  end

  always_comb begin
    st_d = st_q; tok_d = tok_q; ocnt_d = ocnt_q; vcnt_d = vcnt_q; err_d = err_q;
    cur_d = cur_q; a_d = a_q; b_d = b_q;
    o_wr = 1'b0; v_wr = 1'b0; o_wa = ocnt_q[OAW-1:0]; v_wa = vcnt_q[VAW-1:0];
    o_wd = tok_q.op; v_wd = tok_q.num;
    rvld_d = rvld_q && !res_ready_i; rval_d = rval_q; rst_d = rst_q;
    dq_d = dq_q; dr_d = dr_q; dd_d = dd_q; dc_d = dc_q; dneg_d = dneg_q;
    tok_ready_o = 1'b0;
    case (st_q)
      iee_pkg::BS_IDLE: begin
        tok_ready_o = 1'b1;
        if (tok_valid_i) begin
          tok_d = tok_i;
          st_d = iee_pkg::BS_NUM;
        end
      end
      iee_pkg::BS_NUM: begin
        if (tok_q.num_vld) begin
          if (vcnt_q == (VAW+1)'(ValDepth)) err_d = fl(err_q, iee_pkg::ST_OVER);
          else begin v_wr = 1'b1; vcnt_d = vcnt_q + 1'b1; end
        end
        st_d = iee_pkg::BS_POPCHK;
      end
      iee_pkg::BS_POPCHK: begin
        if (!stop) begin
          ocnt_d = ocnt_q - 1'b1;
          cur_d = otop_q;
          if (tok_q.kind == iee_pkg::TK_END && otop_q == iee_pkg::OPC_LPAR)
            st_d = iee_pkg::BS_POPCHK;
          else if (vcnt_q < (VAW+1)'(2)) begin
            err_d = fl(err_q, iee_pkg::ST_UNDER);
            st_d = iee_pkg::BS_POPCHK;
          end else st_d = iee_pkg::BS_READ;
        end else begin
          case (tok_q.kind)
            iee_pkg::TK_OP, iee_pkg::TK_LPAR: begin
              o_wd = (tok_q.kind == iee_pkg::TK_LPAR) ? iee_pkg::OPC_LPAR : tok_q.op;
              if (ocnt_q == (OAW+1)'(OpDepth)) err_d = fl(err_q, iee_pkg::ST_OVER);
              else begin o_wr = 1'b1; ocnt_d = ocnt_q + 1'b1; end
              st_d = iee_pkg::BS_IDLE;
            end
            iee_pkg::TK_RPAR: begin
              if (ocnt_q != '0) ocnt_d = ocnt_q - 1'b1;
              st_d = iee_pkg::BS_IDLE;
            end
            iee_pkg::TK_END: begin
              if (vcnt_q == '0) err_d = fl(err_q, iee_pkg::ST_UNDER);
              st_d = iee_pkg::BS_EMIT;
            end
            default: st_d = iee_pkg::BS_IDLE;
          endcase
          // final operator or paren: flush next; the pass through NUM refreshes the registered top
          if (tok_q.last && tok_q.kind != iee_pkg::TK_END) begin
            tok_d.kind = iee_pkg::TK_END;
            tok_d.num_vld = 1'b0;
            st_d = iee_pkg::BS_NUM;
          end
        end
      end
      iee_pkg::BS_READ: begin
        // operands from the top two entries (registered below)
        vcnt_d = vcnt_q - 2'd2;
        st_d = iee_pkg::BS_EXEC;
      end
      iee_pkg::BS_EXEC: begin
        v_wa = vcnt_q[VAW-1:0];
        v_wr = 1'b1;
        vcnt_d = vcnt_q + 1'b1;
        st_d = iee_pkg::BS_POPCHK;
        case (cur_q)
          iee_pkg::OPC_ADD: v_wd = a_q + b_q;
          iee_pkg::OPC_SUB: v_wd = a_q - b_q;
          iee_pkg::OPC_MUL: v_wd = a_q * b_q;
          default: begin
            if (b_q == '0) begin
              err_d = fl(err_q, iee_pkg::ST_DIV0);
              v_wd = '0;
            end else begin
              v_wr = 1'b0; vcnt_d = vcnt_q;
              dq_d = a_q[31] ? -a_q : a_q;
              dd_d = b_q[31] ? -b_q : b_q;
              dneg_d = a_q[31] ^ b_q[31];
              dr_d = '0; dc_d = 6'd32;
              st_d = iee_pkg::BS_DIV;
            end
          end
        endcase
      end
      iee_pkg::BS_DIV: begin
        if (dc_q != '0) begin
          if (!dsub[32]) begin dr_d = dsub[31:0]; dq_d = {dq_q[30:0], 1'b1}; end
          else begin dr_d = dshift; dq_d = {dq_q[30:0], 1'b0}; end
          dc_d = dc_q - 1'b1;
        end else begin
          v_wr = 1'b1;
          v_wd = dneg_q ? -dq_q : dq_q;
          vcnt_d = vcnt_q + 1'b1;
          st_d = iee_pkg::BS_POPCHK;
        end
      end
      iee_pkg::BS_EMIT: begin
        if (!rvld_q || res_ready_i) begin
          rvld_d = 1'b1;
          rst_d = err_q;
          rval_d = (err_q == iee_pkg::ST_OK) ? a_q : '0;
          ocnt_d = '0; vcnt_d = '0; err_d = iee_pkg::ST_OK;
          st_d = iee_pkg::BS_IDLE;
        end
      end
      default: st_d = iee_pkg::BS_IDLE;
    endcase
  end

  // registered stack reads: top op, and operands/result
  always_ff @(posedge clk_i) begin
    if (o_wr) ostk_q[o_wa] <= o_wd;
    if (v_wr) vstk_q[v_wa] <= v_wd;
    otop_q <= ostk_q[ocnt_d[OAW-1:0] - 1'b1];
    if (st_q == iee_pkg::BS_POPCHK) begin
      b_q <= vstk_q[vcnt_q[VAW-1:0] - 1'b1];
      a_q <= vstk_q[vcnt_q[VAW-1:0] - 2'd2];
      if (stop) a_q <= vstk_q[vcnt_q[VAW-1:0] - 1'b1];
    end else begin
      a_q <= a_d;
      b_q <= b_d;
    end
    tok_q <= tok_d;
    cur_q <= cur_d;
    rval_q <= rval_d;
    dq_q <= dq_d; dr_q <= dr_d; dd_q <= dd_d; dc_q <= dc_d; dneg_q <= dneg_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= iee_pkg::BS_IDLE;
      ocnt_q <= '0; vcnt_q <= '0; err_q <= '0;
      rvld_q <= 1'b0; rst_q <= '0;
    end else begin
      st_q <= st_d;
      ocnt_q <= ocnt_d; vcnt_q <= vcnt_d; err_q <= err_d;
      rvld_q <= rvld_d; rst_q <= rst_d;
    end
  end
endmodule
